// ----- sv/broadcast_source_index_core_macros.svh -----
// Assertion macros for the broadcast source index core checker.
// Included by the checker file only; needs nothing else.
`ifndef BROADCAST_SOURCE_INDEX_CORE_MACROS_SVH
`define BROADCAST_SOURCE_INDEX_CORE_MACROS_SVH

// Check a property on the rising clock edge, muted while reset is held
`define BSI_ASSERT_ON(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock edge, also while reset is held
`define BSI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/bsi_pkg.sv -----
// Shared constants and types of the broadcast source index core.
// No dependencies; the core, its submodules and the testbench import it.
package bsi_pkg;

    // Width of one dimension size register
    localparam int DIM_W = 13;
    // Width of the configuration register index
    localparam int CFG_IDX_W = 3;
    // Dimensions that have configuration registers
    localparam int REG_DIMS = 4;

    // Register index of out_dim0 and of src_dim0
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_BASE = 3'd4;

    // Shape checks derived from the configuration
    typedef struct packed {
        logic dim_zero;      // some result dimension is zero
        logic incompat;      // some source dimension is neither 1 nor the result size
    } bsi_shape_t;

endpackage

// ----- sv/bsi_in_if.sv -----
// Request channel of the broadcast source index core.
// No dependencies.
interface bsi_in_if #(
    parameter int INDEX_BITS = 24
) ();
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] result_flat_index;

    modport source (output valid, output result_flat_index, input ready);
    modport sink   (input valid, input result_flat_index, output ready);
endinterface

// ----- sv/bsi_out_if.sv -----
// Result channel of the broadcast source index core.
// No dependencies.
interface bsi_out_if #(
    parameter int INDEX_BITS = 24
) ();
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] source_flat_index;
    logic                  index_out_of_range;
    logic                  shapes_incompatible;

    modport source (output valid, output source_flat_index, output index_out_of_range,
                    output shapes_incompatible, input ready);
    modport sink   (input valid, input source_flat_index, input index_out_of_range,
                    input shapes_incompatible, output ready);
endinterface

// ----- sv/broadcast_source_index_core.sv -----
// Broadcast source index core: maps a flat index of the broadcast result tensor to the
// flat index of its source element. One request is taken every clock cycle, and a
// stalled result channel holds the whole pipeline. The index is split into coordinates
// by a chain of restoring dividers, one quotient bit per stage, then recombined through
// one multiply stage and one add stage per dimension after the outermost. Sizes are
// written through cfg_we/cfg_index/cfg_data (0..3 result sizes, 4..7 source sizes, all
// reset to 1) and may change only while no request is in flight. The index is 0 when
// index_out_of_range or shapes_incompatible is set.
// Depends on bsi_pkg, bsi_in_if, bsi_out_if, bsi_cfg_regs, bsi_div_stage, bsi_recombine.
module broadcast_source_index_core #(
    parameter int MAX_DIMS   = 4,
    parameter int INDEX_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bsi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsi_pkg::DIM_W-1:0]     cfg_data,
    bsi_in_if.sink                        in_ch,
    bsi_out_if.source                     out_ch
);
    import bsi_pkg::*;

    localparam int ND   = (MAX_DIMS < REG_DIMS) ? MAX_DIMS : REG_DIMS;
    localparam int IB   = INDEX_BITS;
    localparam int NDIV = ND * IB;

    logic [ND-1:0][DIM_W-1:0] out_dim;
    logic [ND-1:0][DIM_W-1:0] src_dim;
    bsi_shape_t               shape;
    logic                     en;

    logic                     vld_w [NDIV+1];
    logic [IB-1:0]            num_w [NDIV+1];
    logic [DIM_W-1:0]         rem_w [NDIV+1];
    logic [ND-1:0][DIM_W-1:0] crd_w [NDIV+1];

    // Advance the whole pipeline unless a result waits unaccepted
    assign en          = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;

    bsi_cfg_regs #(
        .ND (ND)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_dim   (out_dim),
        .src_dim   (src_dim),
        .shape     (shape)
    );

    // Feed the divider chain from the request
    assign vld_w[0] = in_ch.valid;
    assign num_w[0] = in_ch.result_flat_index;
    assign rem_w[0] = '0;
    assign crd_w[0] = '0;

    // Split the index innermost dimension first
    for (genvar s = 0; s < NDIV; s++) begin : g_div
        localparam int D = ND - 1 - s / IB;

        bsi_div_stage #(
            .IB      (IB),
            .ND      (ND),
            .DIM_SEL (D),
            .LAST    ((s % IB) == (IB - 1))
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vld_in  (vld_w[s]),
            .num_in  (num_w[s]),
            .rem_in  (rem_w[s]),
            .crd_in  (crd_w[s]),
            .divisor (out_dim[D]),
            .vld_out (vld_w[s+1]),
            .num_out (num_w[s+1]),
            .rem_out (rem_w[s+1]),
            .crd_out (crd_w[s+1])
        );
    end

    bsi_recombine #(
        .IB (IB),
        .ND (ND)
    ) u_recomb (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (vld_w[NDIV]),
        .quot_in  (num_w[NDIV]),
        .crd_in   (crd_w[NDIV]),
        .src_dim  (src_dim),
        .shape    (shape),
        .vld_out  (out_ch.valid),
        .src_idx  (out_ch.source_flat_index),
        .oor      (out_ch.index_out_of_range),
        .incompat (out_ch.shapes_incompatible)
    );

endmodule

// ----- sv/bsi_cfg_regs.sv -----
// Dimension size registers and derived shape checks.
// Depends on bsi_pkg.
module bsi_cfg_regs #(
    parameter int ND = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [bsi_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bsi_pkg::DIM_W-1:0]             cfg_data,
    output logic [ND-1:0][bsi_pkg::DIM_W-1:0]     out_dim,
    output logic [ND-1:0][bsi_pkg::DIM_W-1:0]     src_dim,
    output bsi_pkg::bsi_shape_t                   shape
);
    import bsi_pkg::*;

    logic [ND-1:0][DIM_W-1:0] out_dim_reg;
    logic [ND-1:0][DIM_W-1:0] src_dim_reg;
    logic [ND-1:0]            zero_d;
    logic [ND-1:0]            bad_d;

    // Hold a result and a source size register per stored dimension; reset to size 1
    for (genvar d = 0; d < ND; d++) begin : g_dim
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                out_dim_reg[d] <= DIM_W'(1);
                src_dim_reg[d] <= DIM_W'(1);
            end
            else if (cfg_we)
            begin
                if (cfg_index == CFG_OUT_BASE + CFG_IDX_W'(d))
                    out_dim_reg[d] <= cfg_data;
                if (cfg_index == CFG_SRC_BASE + CFG_IDX_W'(d))
                    src_dim_reg[d] <= cfg_data;
            end
        end

        // Flag a zero result size and a mismatched source size
        assign zero_d[d] = (out_dim_reg[d] == '0);
        assign bad_d[d]  = (src_dim_reg[d] != DIM_W'(1)) && (src_dim_reg[d] != out_dim_reg[d]);
    end

    assign out_dim        = out_dim_reg;
    assign src_dim        = src_dim_reg;
    assign shape.dim_zero = |zero_d;
    assign shape.incompat = |bad_d;

endmodule

// ----- sv/bsi_div_stage.sv -----
// One restoring division step: one quotient bit per stage.
// Depends on bsi_pkg.
module bsi_div_stage #(
    parameter int IB      = 24,
    parameter int ND      = 4,
    parameter int DIM_SEL = 0,
    parameter bit LAST    = 1'b0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              vld_in,
    input  logic [IB-1:0]                     num_in,
    input  logic [bsi_pkg::DIM_W-1:0]         rem_in,
    input  logic [ND-1:0][bsi_pkg::DIM_W-1:0] crd_in,
    input  logic [bsi_pkg::DIM_W-1:0]         divisor,
    output logic                              vld_out,
    output logic [IB-1:0]                     num_out,
    output logic [bsi_pkg::DIM_W-1:0]         rem_out,
    output logic [ND-1:0][bsi_pkg::DIM_W-1:0] crd_out
);
    import bsi_pkg::*;

    logic                     vld_reg;
    logic [IB-1:0]            num_reg;
    logic [DIM_W-1:0]         rem_reg;
    logic [ND-1:0][DIM_W-1:0] crd_reg;

    logic [DIM_W:0]           trial;
    logic [DIM_W:0]           diff;
    logic                     ge;
    logic [DIM_W-1:0]         rem_step;
    logic [IB-1:0]            num_next;
    logic [DIM_W-1:0]         rem_next;
    logic [ND-1:0][DIM_W-1:0] crd_next;

    // Shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        trial    = {rem_in, num_in[IB-1]};
        diff     = trial - {1'b0, divisor};
        ge       = (trial >= {1'b0, divisor});
        rem_step = ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
        num_next = {num_in[IB-2:0], ge};
        crd_next = crd_in;
        rem_next = rem_step;
        // On the last bit, store the coordinate and restart the remainder
        if (LAST)
        begin
            crd_next[DIM_SEL] = rem_step;
            rem_next          = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            crd_reg <= crd_next;
        end
    end

    assign vld_out = vld_reg;
    assign num_out = num_reg;
    assign rem_out = rem_reg;
    assign crd_out = crd_reg;

endmodule

// ----- sv/bsi_recombine.sv -----
// Recombines coordinates with source sizes (Horner form) and forms flags.
// Depends on bsi_pkg.
module bsi_recombine #(
    parameter int IB = 24,
    parameter int ND = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              vld_in,
    input  logic [IB-1:0]                     quot_in,
    input  logic [ND-1:0][bsi_pkg::DIM_W-1:0] crd_in,
    input  logic [ND-1:0][bsi_pkg::DIM_W-1:0] src_dim,
    input  bsi_pkg::bsi_shape_t               shape,
    output logic                              vld_out,
    output logic [IB-1:0]                     src_idx,
    output logic                              oor,
    output logic                              incompat
);
    import bsi_pkg::*;

    localparam int NS = 2 * (ND - 1);

    logic                     vld_reg [NS+1];
    logic [IB-1:0]            acc_reg [NS+1];
    logic                     qnz_reg [NS+1];
    logic [ND-1:0][DIM_W-1:0] crd_reg [NS+1];

    logic                     out_vld_reg;
    logic [IB-1:0]            out_idx_reg;
    logic                     out_oor_reg;
    logic                     out_inc_reg;

    logic                     oor_next;
    logic                     inc_next;

    // Entry: load the outermost coordinate, drop it if broadcast
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg[0] <= (src_dim[0] == DIM_W'(1)) ? '0 : IB'(crd_in[0]);
            qnz_reg[0] <= |quot_in;
            crd_reg[0] <= crd_in;
        end
    end

    // Horner steps: multiply by the source size, then add the next coordinate
    for (genvar j = 0; j < NS; j++) begin : g_step
        localparam int T = j / 2 + 1;

        logic [IB+DIM_W-1:0] mul_full;
        logic [IB-1:0]       acc_next;

        assign mul_full = {{DIM_W{1'b0}}, acc_reg[j]} * {{IB{1'b0}}, src_dim[T]};

        if (j % 2 == 0) begin : g_mul
            assign acc_next = mul_full[IB-1:0];
        end
        else begin : g_add
            assign acc_next = acc_reg[j] +
                ((src_dim[T] == DIM_W'(1)) ? '0 : IB'(crd_reg[j][T]));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j+1] <= 1'b0;
            else if (en)
                vld_reg[j+1] <= vld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[j+1] <= acc_next;
                qnz_reg[j+1] <= qnz_reg[j];
                crd_reg[j+1] <= crd_reg[j];
            end
        end
    end

    // Output: zero the index when either flag is raised
    assign oor_next = qnz_reg[NS] | shape.dim_zero;
    assign inc_next = shape.incompat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= vld_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_idx_reg <= (oor_next || inc_next) ? '0 : acc_reg[NS];
            out_oor_reg <= oor_next;
            out_inc_reg <= inc_next;
        end
    end

    assign vld_out  = out_vld_reg;
    assign src_idx  = out_idx_reg;
    assign oor      = out_oor_reg;
    assign incompat = out_inc_reg;

endmodule

// ----- sv/bsi_checker.sv -----
// Port-level checks of the broadcast source index core, bound to the top level.
// Depends on broadcast_source_index_core_macros.svh and the top level it binds to.
`include "broadcast_source_index_core_macros.svh"

module bsi_checker #(
    parameter int INDEX_BITS = 24
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [INDEX_BITS-1:0] source_flat_index,
    input logic                  index_out_of_range,
    input logic                  shapes_incompatible
);

    // A flagged result carries source index zero
    `BSI_ASSERT_ON(a_flag_zero, clk, rst_n, out_valid && (index_out_of_range || shapes_incompatible) |-> source_flat_index == '0, "flagged result with nonzero source index")

    // Requests are taken exactly when the pipeline advances
    `BSI_ASSERT_ON(a_ready_adv, clk, rst_n, in_ready == (!out_valid || out_ready), "request ready does not follow result stall")

    // A stalled result holds its index
    `BSI_ASSERT_ON(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(source_flat_index), "stalled result changed")

    // No result during reset
    `BSI_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |-> !out_valid, "result valid during reset")

endmodule

bind broadcast_source_index_core bsi_checker #(
    .INDEX_BITS (INDEX_BITS)
) u_bsi_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_ready            (in_ch.ready),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .source_flat_index   (out_ch.source_flat_index),
    .index_out_of_range  (out_ch.index_out_of_range),
    .shapes_incompatible (out_ch.shapes_incompatible)
);

// ----- test/tb_top.sv -----
// Testbench for broadcast_source_index_core: random and directed flat indices under
// several result/source shapes, checked against an in-bench index mapping predictor.
// Depends on bsi_pkg, bsi_in_if, bsi_out_if and the core itself.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bsi_pkg::*;

    localparam int NDIM      = 4;
    localparam int IDX_W     = 24;
    localparam int DRAIN     = 120;
    localparam int WDOG_MAX  = 3000;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        logic [IDX_W-1:0] src_index;
        logic             out_of_range;
        logic             incompat;
    } src_map_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0] cfg_data;

    bsi_in_if  #(.INDEX_BITS(IDX_W)) in_ch ();
    bsi_out_if #(.INDEX_BITS(IDX_W)) out_ch ();

    broadcast_source_index_core #(.MAX_DIMS(NDIM), .INDEX_BITS(IDX_W)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Shadow copy of the shape registers
    logic [DIM_W-1:0] out_size [NDIM];
    logic [DIM_W-1:0] src_size [NDIM];

    logic [IDX_W-1:0] pending_index [$];
    src_map_t         expected_map [$];
    int               fail_count;
    int               idle_cycles;
    int               send_gap_max;
    int               recv_gap_max;
    logic             long_hold_req;
    logic             long_hold_done;
    int               hold_count;
    int               send_gap;
    logic             in_stalled;

    // Map a result flat index to the expected source index and flags
    function automatic src_map_t map_index(logic [IDX_W-1:0] flat);
        src_map_t   r;
        longint unsigned count;
        longint unsigned rem;
        longint unsigned stride;
        longint unsigned acc;
        longint unsigned coord [NDIM];
        count = 1;
        r.incompat = 1'b0;
        for (int d = 0; d < NDIM; d++)
        begin
            count = count * out_size[d];
            if (count > (64'd1 << 40))
                count = 64'd1 << 40;
            if (src_size[d] != 1 && src_size[d] != out_size[d])
                r.incompat = 1'b1;
        end
        r.out_of_range = (flat >= count);
        acc = 0;
        if (!r.out_of_range && !r.incompat)
        begin
            rem = flat;
            for (int d = NDIM - 1; d >= 0; d--)
            begin
                coord[d] = rem % out_size[d];
                rem = rem / out_size[d];
            end
            stride = 1;
            for (int d = NDIM - 1; d >= 0; d--)
            begin
                if (src_size[d] != 1)
                    acc = acc + coord[d] * stride;
                stride = stride * src_size[d];
            end
        end
        r.src_index = acc[IDX_W-1:0];
        return r;
    endfunction

    // Element count of the current result shape, capped at the index range
    function automatic longint unsigned element_count();
        longint unsigned c;
        c = 1;
        for (int d = 0; d < NDIM; d++)
            c = c * out_size[d];
        return (c > (64'd1 << IDX_W)) ? (64'd1 << IDX_W) : c;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive request channel: hold a request until taken, then maybe idle
    always @(negedge clk)
    begin
        if (rst_n && !in_stalled)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_index.size() > 0)
            begin
                in_ch.valid <= 1'b1;
                in_ch.result_flat_index <= pending_index.pop_front();
                if (send_gap_max == 0 || $urandom_range(0, 1) == 0)
                    send_gap <= 0;
                else if ($urandom_range(0, 19) == 0)
                    send_gap <= $urandom_range(10, send_gap_max * 10);
                else
                    send_gap <= $urandom_range(1, send_gap_max);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Drive result ready: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_count > 0)
            begin
                hold_count <= hold_count - 1;
                out_ch.ready <= 1'b0;
            end
            else if (long_hold_req && !long_hold_done)
            begin
                long_hold_done <= 1'b1;
                hold_count <= LONG_HOLD;
                out_ch.ready <= 1'b0;
            end
            else if (recv_gap_max == 0 || $urandom_range(0, 2) != 0)
                out_ch.ready <= 1'b1;
            else
            begin
                out_ch.ready <= 1'b0;
                if ($urandom_range(0, 15) == 0)
                    hold_count <= $urandom_range(10, recv_gap_max * 10);
                else
                    hold_count <= $urandom_range(0, recv_gap_max);
            end
        end
    end

    // Predict on accepted requests, check accepted results, watch for hangs
    always @(posedge clk)
    begin
        src_map_t want;
        if (rst_n)
        begin
            in_stalled <= in_ch.valid && !in_ch.ready;
            if (in_ch.valid && in_ch.ready)
                expected_map.insert(expected_map.size(), map_index(in_ch.result_flat_index));
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_map.size() == 0)
                begin
                    $error("result with no request outstanding: index %0h",
                           out_ch.source_flat_index);
                    fail_count++;
                end
                else
                begin
                    want = expected_map.pop_front();
                    if (out_ch.source_flat_index !== want.src_index)
                    begin
                        $error("source_flat_index: expected %0h actual %0h",
                               want.src_index, out_ch.source_flat_index);
                        fail_count++;
                    end
                    if (out_ch.index_out_of_range !== want.out_of_range)
                    begin
                        $error("index_out_of_range: expected %0b actual %0b",
                               want.out_of_range, out_ch.index_out_of_range);
                        fail_count++;
                    end
                    if (out_ch.shapes_incompatible !== want.incompat)
                    begin
                        $error("shapes_incompatible: expected %0b actual %0b",
                               want.incompat, out_ch.shapes_incompatible);
                        fail_count++;
                    end
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Write one shape register and its shadow copy
    task automatic write_size(input int reg_idx, input logic [DIM_W-1:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = reg_idx[CFG_IDX_W-1:0];
        cfg_data = value;
        if (reg_idx < REG_DIMS)
            out_size[reg_idx] = value;
        else
            src_size[reg_idx - REG_DIMS] = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_shape(input logic [DIM_W-1:0] o [NDIM], input logic [DIM_W-1:0] s [NDIM]);
        for (int d = 0; d < NDIM; d++)
        begin
            write_size(int'(CFG_OUT_BASE) + d, o[d]);
            write_size(int'(CFG_SRC_BASE) + d, s[d]);
        end
    endtask

    // Wait until every request has come back, then let the pipeline settle
    task automatic drain();
        idle_cycles = 0;
        wait (pending_index.size() == 0 && expected_map.size() == 0 && !in_ch.valid);
        repeat (DRAIN) @(negedge clk);
    endtask

    // Queue random indices: mostly inside the element count, some anywhere
    task automatic queue_random(input int n);
        longint unsigned c;
        c = element_count();
        for (int i = 0; i < n; i++)
        begin
            if (c > 0 && $urandom_range(0, 4) != 0)
                pending_index.insert(pending_index.size(), IDX_W'($urandom % c));
            else
                pending_index.insert(pending_index.size(), IDX_W'($urandom));
        end
    endtask

    task automatic queue_edges();
        longint unsigned c;
        c = element_count();
        pending_index.insert(pending_index.size(), '0);
        pending_index.insert(pending_index.size(), {IDX_W{1'b1}});
        if (c > 0)
        begin
            pending_index.insert(pending_index.size(), IDX_W'(c - 1));
            pending_index.insert(pending_index.size(), IDX_W'(c));
        end
    endtask

    initial
    begin
        logic [DIM_W-1:0] o [NDIM];
        logic [DIM_W-1:0] s [NDIM];
        fail_count = 0;
        idle_cycles = 0;
        send_gap = 0;
        hold_count = 0;
        send_gap_max = 2;
        recv_gap_max = 2;
        long_hold_req = 1'b0;
        long_hold_done = 1'b0;
        in_stalled = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.result_flat_index = '0;
        out_ch.ready = 1'b0;
        for (int d = 0; d < NDIM; d++)
        begin
            out_size[d] = 1;
            src_size[d] = 1;
        end
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset shape: a single element
        queue_edges();
        pending_index.insert(pending_index.size(), 24'h555555);
        pending_index.insert(pending_index.size(), 24'hAAAAAA);
        drain();

        // Large shape of 4096 per dimension, all dimensions matching
        o = '{13'd4096, 13'd4096, 13'd4096, 13'd4096};
        s = o;
        set_shape(o, s);
        queue_edges();
        queue_random(3);
        drain();

        // Zero-sized result dimension: everything out of range
        o = '{13'd3, 13'd4, 13'd0, 13'd5};
        s = '{13'd1, 13'd4, 13'd1, 13'd5};
        set_shape(o, s);
        queue_edges();
        drain();

        // Result size 1 against a larger source size, with out-of-range too
        o = '{13'd2, 13'd1, 13'd6, 13'd7};
        s = '{13'd1, 13'd5, 13'd6, 13'd7};
        set_shape(o, s);
        queue_edges();
        drain();

        // Source size 0 against result size 0 is compatible
        o = '{13'd0, 13'd8191, 13'd8191, 13'd8191};
        s = '{13'd0, 13'd1, 13'd8191, 13'd1};
        set_shape(o, s);
        queue_edges();
        drain();

        // Source size 0 against a nonzero result size
        o = '{13'd4, 13'd3, 13'd2, 13'd9};
        s = '{13'd0, 13'd3, 13'd1, 13'd9};
        set_shape(o, s);
        queue_edges();
        drain();

        // Random shapes with broadcasting, varied idling; one long burst fills the pipeline
        for (int ph = 0; ph < 12; ph++)
        begin
            for (int d = 0; d < NDIM; d++)
            begin
                o[d] = (ph == 5) ? DIM_W'($urandom_range(100, 300)) : DIM_W'($urandom_range(1, 9));
                case ($urandom_range(0, 9))
                    0: s[d] = DIM_W'($urandom_range(0, 12));
                    1, 2, 3, 4: s[d] = 13'd1;
                    default: s[d] = o[d];
                endcase
            end
            send_gap_max = (ph % 3 == 0) ? 0 : $urandom_range(1, 4);
            recv_gap_max = (ph % 4 == 1) ? 0 : $urandom_range(1, 4);
            set_shape(o, s);
            queue_edges();
            queue_random((ph == 3) ? 200 : 52);
            if (ph == 3)
                long_hold_req = 1'b1;
            drain();
        end

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- broadcast_source_index_core.f -----
+incdir+sv
sv/bsi_pkg.sv
sv/bsi_in_if.sv
sv/bsi_out_if.sv
sv/bsi_cfg_regs.sv
sv/bsi_div_stage.sv
sv/bsi_recombine.sv
sv/broadcast_source_index_core.sv
sv/bsi_checker.sv
test/tb_top.sv
